/* src/uer_pkg.sv */
// Shared constants, register codes and control types for the echo ranger.
`default_nettype none

package uer_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int BAR_LEDS    = 5;

    localparam int TICK_W      = 11;
    localparam int CM_W        = 8;
    localparam int PERIOD_W    = 16;
    localparam int STEP_W      = 8;
    localparam int DIST_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Echo time in microseconds and the divider width
    localparam int PROD_W      = COUNT_WIDTH + TICK_W;
    localparam int DIVCNT_W    = $clog2(PROD_W);
    localparam int BAR_PROD_W  = STEP_W + $clog2(BAR_LEDS + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_US_PER_TICK       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_US_PER_CM         = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_PERIOD_MS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BAR_STEP_CM       = 2'd3;

    localparam logic [TICK_W-1:0]   US_PER_TICK_RST       = 11'd64;
    localparam logic [CM_W-1:0]     US_PER_CM_RST         = 8'd58;
    localparam logic [PERIOD_W-1:0] TRIGGER_PERIOD_MS_RST = 16'd1000;
    localparam logic [STEP_W-1:0]   BAR_STEP_CM_RST       = 8'd2;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_step;
        logic bar;
        logic out_load;
    } uer_cmd_t;

    typedef struct packed {
        logic fall_edge;
    } uer_status_t;

endpackage

`default_nettype wire

/* src/uer_sample_if.sv */
// Input channel: one echo sample with its tick flags.
`default_nettype none

interface uer_sample_if;
    logic valid;
    logic ready;
    logic echo_level;
    logic timer_tick;
    logic ms_tick;

    modport source (output valid, output echo_level, output timer_tick, output ms_tick,
                    input ready);
    modport sink   (input valid, input echo_level, input timer_tick, input ms_tick,
                    output ready);
endinterface

`default_nettype wire

/* src/uer_result_if.sv */
// Output channel: trigger request, measurement and bar pattern.
`default_nettype none

interface uer_result_if;
    logic                          valid;
    logic                          ready;
    logic                          trigger_start;
    logic                          measure_done;
    logic [uer_pkg::DIST_W-1:0]    distance_cm;
    logic [uer_pkg::BAR_LEDS-1:0]  led_bar;

    modport source (output valid, output trigger_start, output measure_done,
                    output distance_cm, output led_bar, input ready);
    modport sink   (input valid, input trigger_start, input measure_done,
                    input distance_cm, input led_bar, output ready);
endinterface

`default_nettype wire

/* src/uer_datapath.sv */
// Datapath: configuration, counters, bit-serial divider, bar graph and output register.
`default_nettype none

module uer_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [uer_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             echo_level,
    input  wire logic                             timer_tick,
    input  wire logic                             ms_tick,
    input  wire uer_pkg::uer_cmd_t                cmd,
    output uer_pkg::uer_status_t                  status,
    output logic                                  trigger_start,
    output logic                                  measure_done,
    output logic [uer_pkg::DIST_W-1:0]            distance_cm,
    output logic [uer_pkg::BAR_LEDS-1:0]          led_bar
);

    logic [uer_pkg::TICK_W-1:0]      us_per_tick_reg;
    logic [uer_pkg::CM_W-1:0]        us_per_cm_reg;
    logic [uer_pkg::PERIOD_W-1:0]    trigger_period_reg;
    logic [uer_pkg::STEP_W-1:0]      bar_step_reg;

    logic                            echo_prev_reg;
    logic [uer_pkg::COUNT_WIDTH-1:0] tick_count_reg;
    logic [uer_pkg::COUNT_WIDTH-1:0] tick_count_next;
    logic [15:0]                     ms_count_reg;
    logic [15:0]                     ms_inc;
    logic [uer_pkg::BAR_LEDS-1:0]    bar_hold_reg;

    logic [uer_pkg::PROD_W-1:0]      work_reg;
    logic [uer_pkg::CM_W-1:0]        rem_reg;
    logic [uer_pkg::CM_W:0]          rem_sh;
    logic [uer_pkg::CM_W:0]          rem_diff;
    logic                            rem_ge;

    logic                            pend_trig_reg;
    logic                            pend_done_reg;
    logic [uer_pkg::DIST_W-1:0]      pend_dist_reg;

    logic                            rise;
    logic                            fall;
    logic                            trig;
    logic [uer_pkg::DIST_W-1:0]      dist_sat;
    logic [uer_pkg::BAR_PROD_W-1:0]  step_k;
    logic [uer_pkg::BAR_LEDS-1:0]    bar_new;

    assign rise = echo_level & ~echo_prev_reg;
    assign fall = ~echo_level & echo_prev_reg;
    assign status.fall_edge = fall;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        if (rise)
        begin
            tick_count_next = '0;
        end
        else if (!fall && timer_tick && (tick_count_reg != '1))
        begin
            tick_count_next = tick_count_reg + 1'b1;
        end
    end

    assign ms_inc = (ms_tick && (ms_count_reg != 16'hFFFF)) ? ms_count_reg + 16'd1
                                                             : ms_count_reg;
    assign trig   = (ms_inc >= trigger_period_reg);

    // Restoring divider: one quotient bit per step, shifted into the work register
    assign rem_sh   = {rem_reg, work_reg[uer_pkg::PROD_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, us_per_cm_reg});
    assign rem_diff = rem_sh - {1'b0, us_per_cm_reg};

    assign dist_sat = (|work_reg[uer_pkg::PROD_W-1:uer_pkg::DIST_W])
                      ? '1 : work_reg[uer_pkg::DIST_W-1:0];

    // Smallest k with distance within k steps lights k LEDs
    always_comb
    begin
        bar_new = '0;
        step_k  = '0;
        for (int k = uer_pkg::BAR_LEDS; k >= 1; k--)
        begin
            step_k = uer_pkg::BAR_PROD_W'(k) * uer_pkg::BAR_PROD_W'(bar_step_reg);
            if (dist_sat <= uer_pkg::DIST_W'(step_k))
            begin
                bar_new = uer_pkg::BAR_LEDS'((1 << k) - 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            us_per_tick_reg    <= uer_pkg::US_PER_TICK_RST;
            us_per_cm_reg      <= uer_pkg::US_PER_CM_RST;
            trigger_period_reg <= uer_pkg::TRIGGER_PERIOD_MS_RST;
            bar_step_reg       <= uer_pkg::BAR_STEP_CM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uer_pkg::REG_US_PER_TICK:
                    us_per_tick_reg <= cfg_data[uer_pkg::TICK_W-1:0];
                uer_pkg::REG_US_PER_CM:
                    us_per_cm_reg <= cfg_data[uer_pkg::CM_W-1:0];
                uer_pkg::REG_TRIGGER_PERIOD_MS:
                    trigger_period_reg <= cfg_data[uer_pkg::PERIOD_W-1:0];
                uer_pkg::REG_BAR_STEP_CM:
                    bar_step_reg <= cfg_data[uer_pkg::STEP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_prev_reg  <= 1'b0;
            tick_count_reg <= '0;
            ms_count_reg   <= '0;
            bar_hold_reg   <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                echo_prev_reg  <= echo_level;
                tick_count_reg <= tick_count_next;
                ms_count_reg   <= trig ? 16'd0 : ms_inc;
            end
            if (cmd.bar)
            begin
                bar_hold_reg <= bar_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_trig_reg <= trig;
            pend_done_reg <= fall;
            pend_dist_reg <= '0;
        end
        else if (cmd.bar)
        begin
            pend_dist_reg <= dist_sat;
        end

        if (cmd.mul)
        begin
            work_reg <= uer_pkg::PROD_W'(tick_count_reg)
                        * uer_pkg::PROD_W'(us_per_tick_reg);
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            work_reg <= {work_reg[uer_pkg::PROD_W-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_diff[uer_pkg::CM_W-1:0] : rem_sh[uer_pkg::CM_W-1:0];
        end

        if (cmd.out_load)
        begin
            trigger_start <= pend_trig_reg;
            measure_done  <= pend_done_reg;
            distance_cm   <= pend_dist_reg;
            led_bar       <= bar_hold_reg;
        end
    end

endmodule

`default_nettype wire

/* src/uer_controller.sv */
// Controller: sequences accept, multiply, divide, bar update and result transfer.
`default_nettype none

module uer_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_ready,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    input  wire uer_pkg::uer_status_t  status,
    output uer_pkg::uer_cmd_t          cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_BAR  = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [uer_pkg::DIVCNT_W-1:0] cnt_reg;
    logic [uer_pkg::DIVCNT_W-1:0] cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       slot_free;

    assign slot_free    = !out_valid_reg || result_ready;
    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.fall_edge ? S_MUL : S_HOLD;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == uer_pkg::DIVCNT_W'(uer_pkg::PROD_W - 1))
                begin
                    state_next = S_BAR;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_BAR:
            begin
                cmd.bar    = 1'b1;
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* src/ultrasonic_echo_ranger_core.sv */
// Top level of the ultrasonic echo ranger: controller, datapath and channel wiring.
`default_nettype none

// Ultrasonic echo ranger. Each sample transfer carries the echo line level and
// two tick flags; each one yields exactly one result transfer. A rising echo edge
// clears the tick counter, timer ticks advance it (saturating), and a falling
// edge converts the count to centimetres: count * us_per_tick / us_per_cm,
// truncated and saturated at 65535, which also refreshes the five-LED bar held
// on led_bar. A millisecond counter raises trigger_start once per
// trigger_period_ms. Timing: a sample without a falling edge goes from the
// transfer straight to the output load; a falling edge goes through the
// transfer, the multiply, one divider step per quotient bit and the bar
// update before the output load, which in both cases waits until the sink
// has taken the previous result or is taking it. The restoring divider
// retires one quotient bit per cycle. A new sample is taken once the
// previous result sits in the output register, even if the sink has not yet
// taken it. Configuration writes take effect at the edge that carries them and
// belong in idle periods; indexes beyond the last register are ignored.

module ultrasonic_echo_ranger_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [uer_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data,
    uer_sample_if.sink                            sample,
    uer_result_if.source                          result
);

    uer_pkg::uer_cmd_t    cmd;
    uer_pkg::uer_status_t status;

    // Sequence each transfer through the shared divider and the output stage
    uer_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Hold configuration and measurement state; drive the result payload
    uer_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .echo_level    (sample.echo_level),
        .timer_tick    (sample.timer_tick),
        .ms_tick       (sample.ms_tick),
        .cmd           (cmd),
        .status        (status),
        .trigger_start (result.trigger_start),
        .measure_done  (result.measure_done),
        .distance_cm   (result.distance_cm),
        .led_bar       (result.led_bar)
    );

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench for the ultrasonic echo ranger core: directed and random ranging checks.
`timescale 1ns / 1ps

module tb;

    import uer_pkg::*;

    // Run guard, generous against the slowest legal run (every falling edge
    // through the divider plus worst-case stalls on both sides)
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    // Settle time after draining, longer than a falling edge needs inside the block
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_ITEMS   = 80;

    typedef struct packed {
        logic                trigger_start;
        logic                measure_done;
        logic [DIST_W-1:0]   distance_cm;
        logic [BAR_LEDS-1:0] led_bar;
    } range_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    uer_sample_if sample_ch ();
    uer_result_if result_ch ();

    ultrasonic_echo_ranger_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // Local copy of the register file, updated as each write lands
    logic [TICK_W-1:0]   us_per_tick_copy;
    logic [CM_W-1:0]     us_per_cm_copy;
    logic [PERIOD_W-1:0] period_copy;
    logic [STEP_W-1:0]   bar_step_copy;

    // Local copy of the ranging state
    logic                   echo_seen;
    logic [COUNT_WIDTH-1:0] tick_total;
    logic [15:0]            ms_total;
    logic [BAR_LEDS-1:0]    bar_lit;

    range_result_t expected_ranges[$];

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned hold_cycles;
    bit          idling_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Echo time in ticks to centimetres: truncating division, saturated
    function automatic logic [DIST_W-1:0] echo_to_cm(input logic [COUNT_WIDTH-1:0] ticks);
        longint unsigned micros;
        longint unsigned cm;
        if (us_per_cm_copy == '0)
            return '1;
        micros = 64'(ticks);
        micros = micros * 64'(us_per_tick_copy);
        cm = micros / 64'(us_per_cm_copy);
        return (cm > 64'd65535) ? '1 : cm[DIST_W-1:0];
    endfunction

    // Thermometer: k low LEDs for the smallest k whose step covers the distance
    function automatic logic [BAR_LEDS-1:0] bar_pattern(input logic [DIST_W-1:0] cm);
        for (int unsigned k = 1; k <= BAR_LEDS; k++)
        begin
            if (cm <= k * bar_step_copy)
                return BAR_LEDS'((1 << k) - 1);
        end
        return '0;
    endfunction

    // Advance the local ranging state by one sample and return its result
    function automatic range_result_t range_sample(input logic echo, input logic tick,
                                                   input logic ms);
        range_result_t res;
        res = '0;
        if (echo && !echo_seen)
            tick_total = '0;
        else if (!echo && echo_seen)
        begin
            res.measure_done = 1'b1;
            res.distance_cm  = echo_to_cm(tick_total);
            bar_lit          = bar_pattern(res.distance_cm);
        end
        else if (tick && tick_total != '1)
            tick_total = tick_total + 1'b1;
        echo_seen = echo;
        if (ms && ms_total != 16'hFFFF)
            ms_total = ms_total + 1'b1;
        if (ms_total >= period_copy)
        begin
            res.trigger_start = 1'b1;
            ms_total = '0;
        end
        res.led_bar = bar_lit;
        return res;
    endfunction

    // Check each result transfer first, then predict for a sample transfer
    // at the same edge, so both share one ordered view of the queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_ranges.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    range_result_t want;
                    want = expected_ranges.pop_front();
                    if (result_ch.trigger_start !== want.trigger_start)
                    begin
                        $error("trigger_start: expected %0d, got %0d",
                               want.trigger_start, result_ch.trigger_start);
                        mismatch_count++;
                    end
                    if (result_ch.measure_done !== want.measure_done)
                    begin
                        $error("measure_done: expected %0d, got %0d",
                               want.measure_done, result_ch.measure_done);
                        mismatch_count++;
                    end
                    if (result_ch.distance_cm !== want.distance_cm)
                    begin
                        $error("distance_cm: expected %0d, got %0d",
                               want.distance_cm, result_ch.distance_cm);
                        mismatch_count++;
                    end
                    if (result_ch.led_bar !== want.led_bar)
                    begin
                        $error("led_bar: expected %b, got %b",
                               want.led_bar, result_ch.led_bar);
                        mismatch_count++;
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
                expected_ranges.push_back(range_sample(sample_ch.echo_level,
                                                       sample_ch.timer_tick,
                                                       sample_ch.ms_tick));
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result sink: a random stall after each transfer while idling is on, plus a long hold-off
    // on request, counted down here one cycle at a time
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (result_ch.valid && result_ch.ready)
            begin
                stall_left = idling_on ? $urandom_range(0, 16) : 0;
                result_ch.ready <= (stall_left == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result_ch.ready <= (stall_left == 0);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Offer one sample and return at the edge that transfers it. Valid stays
    // high on return; the next call either reuses it or drops it for a gap.
    task automatic send_sample(input logic echo, input logic tick, input logic ms);
        int unsigned gap;
        gap = idling_on ? $urandom_range(0, 16) : 0;
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.echo_level <= echo;
        sample_ch.timer_tick <= tick;
        sample_ch.ms_tick    <= ms;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Rise, a run of timer ticks, then the falling edge that measures them
    task automatic send_pulse(input int unsigned ticks, input logic ms);
        send_sample(1'b1, 1'b0, ms);
        repeat (ticks) send_sample(1'b1, 1'b1, ms);
        send_sample(1'b0, 1'b0, ms);
    endtask

    // Drop valid, drain all expected results, then let the block go quiet
    task automatic wait_quiet();
        sample_ch.valid <= 1'b0;
        while (expected_ranges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            REG_US_PER_TICK:       us_per_tick_copy = value[TICK_W-1:0];
            REG_US_PER_CM:         us_per_cm_copy   = value[CM_W-1:0];
            REG_TRIGGER_PERIOD_MS: period_copy      = value[PERIOD_W-1:0];
            REG_BAR_STEP_CM:       bar_step_copy    = value[STEP_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] us_tick,
                                  input logic [CFG_DATA_W-1:0] us_cm,
                                  input logic [CFG_DATA_W-1:0] period,
                                  input logic [CFG_DATA_W-1:0] step);
        write_reg(REG_US_PER_TICK, us_tick);
        write_reg(REG_US_PER_CM, us_cm);
        write_reg(REG_TRIGGER_PERIOD_MS, period);
        write_reg(REG_BAR_STEP_CM, step);
    endtask

    // Reset settings: all flag combinations, tick ignored on the rise,
    // tick on the fall, and an immediate fall with an empty count
    task automatic test_edge_handling();
        idling_on = 1'b1;
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1);
        send_pulse(5, 1'b0);
        wait_quiet();
    endtask

    // Zero divisor saturates, zero tick length gives zero, zero step lights
    // only the first LED at distance zero
    task automatic test_zero_registers();
        idling_on = 1'b0;
        apply_settings(16'd64, 16'd0, 16'd1000, 16'd0);
        send_pulse(3, 1'b0);
        wait_quiet();
        apply_settings(16'd0, 16'd58, 16'd1000, 16'd0);
        send_pulse(4, 1'b0);
        wait_quiet();
    endtask

    // Period zero fires on every sample; period one and two follow ms ticks
    task automatic test_trigger_period();
        idling_on = 1'b1;
        apply_settings(16'd64, 16'd58, 16'd0, 16'd2);
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        wait_quiet();
        write_reg(REG_TRIGGER_PERIOD_MS, 16'd1);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        wait_quiet();
        write_reg(REG_TRIGGER_PERIOD_MS, 16'd2);
        repeat (4) send_sample(1'b0, 1'b0, 1'b1);
        wait_quiet();
    endtask

    // Register extremes; all data bits set on the tick length register
    task automatic test_register_extremes();
        idling_on = 1'b0;
        apply_settings(16'hFFFF, 16'd1, 16'd65535, 16'd255);
        send_pulse(40, 1'b1);
        wait_quiet();
        apply_settings(16'd1, 16'd255, 16'd1, 16'd1);
        send_pulse(3, 1'b1);
        send_pulse(0, 1'b0);
        wait_quiet();
        apply_settings(16'd1024, 16'd255, 16'd1000, 16'd1);
        send_pulse(1, 1'b0);
        send_pulse(5, 1'b0);
        wait_quiet();
    endtask

    // Hold echo high for a long run of ticks at one-to-one scaling, with an
    // ms tick on every sample so the trigger period rolls over several times
    task automatic test_long_echo();
        idling_on = 1'b0;
        apply_settings(16'd1, 16'd1, 16'd64, 16'd255);
        send_pulse(200, 1'b1);
        wait_quiet();
    endtask

    // Stop the sink for a long stretch while samples keep coming, so the
    // block fills and stalls its input
    task automatic test_output_backpressure();
        idling_on = 1'b0;
        apply_settings(16'd64, 16'd58, 16'd3, 16'd2);
        hold_cycles = 400;
        repeat (8) send_pulse(3, 1'b1);
        wait_quiet();
    endtask

    // Mostly well-formed echo pulses with random contents, some noise,
    // under several random settings
    task automatic test_random_ranging();
        int unsigned phase_items;
        int unsigned high_len;
        logic [CFG_DATA_W-1:0] us_tick, us_cm, period, step;
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       us_tick = 16'd1;
                1:       us_tick = 16'd2047;
                default: us_tick = CFG_DATA_W'($urandom_range(1, 128));
            endcase
            case ($urandom_range(0, 3))
                0:       us_cm = 16'd1;
                1:       us_cm = 16'd255;
                default: us_cm = CFG_DATA_W'($urandom_range(1, 255));
            endcase
            case ($urandom_range(0, 5))
                0:       period = 16'd1;
                1:       period = 16'd65535;
                default: period = CFG_DATA_W'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 3))
                0:       step = 16'd1;
                1:       step = 16'd255;
                default: step = CFG_DATA_W'($urandom_range(1, 30));
            endcase
            apply_settings(us_tick, us_cm, period, step);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                // Idle-free stretches now and then
                idling_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 6) != 0)
                begin
                    high_len = $urandom_range(0, 40);
                    repeat ($urandom_range(0, 3))
                    begin
                        send_sample(1'b0, 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
                        phase_items++;
                    end
                    send_sample(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    repeat (high_len)
                        send_sample(1'b1, ($urandom_range(0, 3) != 0),
                                    1'($urandom_range(0, 1)));
                    send_sample(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    phase_items += high_len + 2;
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
                        phase_items++;
                    end
                end
            end
            wait_quiet();
        end
    endtask

    initial
    begin
        mismatch_count   = 0;
        cycle_count      = 0;
        hold_cycles      = 0;
        idling_on        = 1'b0;
        us_per_tick_copy = US_PER_TICK_RST;
        us_per_cm_copy   = US_PER_CM_RST;
        period_copy      = TRIGGER_PERIOD_MS_RST;
        bar_step_copy    = BAR_STEP_CM_RST;
        echo_seen        = 1'b0;
        tick_total       = '0;
        ms_total         = '0;
        bar_lit          = '0;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_US_PER_TICK;
        cfg_data             <= '0;
        sample_ch.valid      <= 1'b0;
        sample_ch.echo_level <= 1'b0;
        sample_ch.timer_tick <= 1'b0;
        sample_ch.ms_tick    <= 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_handling();
        test_zero_registers();
        test_trigger_period();
        test_register_extremes();
        test_long_echo();
        test_output_backpressure();
        test_random_ranging();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* ultrasonic_echo_ranger_core.f */
src/uer_pkg.sv
src/uer_sample_if.sv
src/uer_result_if.sv
src/uer_datapath.sv
src/uer_controller.sv
src/ultrasonic_echo_ranger_core.sv
verif/tb.sv
